// ===== rtl/phe_pkg.sv =====
`default_nettype none

package phe_pkg;

    localparam int SLOT_W = 6;
    localparam int NUM_CHAN = 6;

    // Positions in the fixed 40-byte output template. Digit positions that
    // belong to leading zeros are skipped by the emitter.
    localparam logic [SLOT_W-1:0] SLOT_FIRST = 6'd0;
    localparam logic [SLOT_W-1:0] SLOT_HALF0 = 6'd36;
    localparam logic [SLOT_W-1:0] SLOT_HALF2 = 6'd38;
    localparam logic [SLOT_W-1:0] SLOT_NL    = 6'd39;

    localparam logic [7:0] BYTE_ESC   = 8'h1B;
    localparam logic [7:0] BYTE_LBR   = 8'h5B;
    localparam logic [7:0] BYTE_SEMI  = 8'h3B;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_TWO   = 8'h32;
    localparam logic [7:0] BYTE_THREE = 8'h33;
    localparam logic [7:0] BYTE_FOUR  = 8'h34;
    localparam logic [7:0] BYTE_EIGHT = 8'h38;
    localparam logic [7:0] BYTE_M     = 8'h6D;
    localparam logic [7:0] BYTE_HB0   = 8'hE2;
    localparam logic [7:0] BYTE_HB1   = 8'h96;
    localparam logic [7:0] BYTE_HB2   = 8'h80;
    localparam logic [7:0] BYTE_NL    = 8'h0A;

    // One decoded column: channel values as three BCD digits each, in the
    // order upper red, green, blue, lower red, green, blue.
    typedef struct packed {
        logic                      open;
        logic                      newline;
        logic [NUM_CHAN-1:0][11:0] bcd;
    } desc_t;

    typedef struct packed {
        logic       present;
        logic [7:0] value;
    } slot_info_t;

endpackage

`default_nettype wire

// ===== rtl/phe_decode.sv =====
`default_nettype none

module phe_decode
    import phe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pixel_valid,
    output logic            pixel_ready,
    input  wire logic [7:0] upper_red,
    input  wire logic [7:0] upper_green,
    input  wire logic [7:0] upper_blue,
    input  wire logic [7:0] upper_alpha,
    input  wire logic [7:0] lower_red,
    input  wire logic [7:0] lower_green,
    input  wire logic [7:0] lower_blue,
    input  wire logic [7:0] lower_alpha,
    input  wire logic       row_end,
    input  wire logic       frame_end,
    output logic            desc_valid,
    input  wire logic       desc_ready,
    output desc_t           desc
);

    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] sh;
        sh = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (sh[11:8] >= 4'd5) sh[11:8] = sh[11:8] + 4'd3;
            if (sh[15:12] >= 4'd5) sh[15:12] = sh[15:12] + 4'd3;
            if (sh[19:16] >= 4'd5) sh[19:16] = sh[19:16] + 4'd3;
            sh = {sh[18:0], 1'b0};
        end
        return sh[19:8];
    endfunction

    logic [31:0] prev_upper_reg, prev_upper_next;
    logic [31:0] prev_lower_reg, prev_lower_next;
    logic        row_start_reg, row_start_next;
    logic        valid_reg, valid_next;
    desc_t       desc_reg, desc_next;
    logic [31:0] upper_color, lower_color;
    logic        take;

    assign upper_color = {upper_alpha, upper_blue, upper_green, upper_red};
    assign lower_color = {lower_alpha, lower_blue, lower_green, lower_red};
    assign pixel_ready = !valid_reg || desc_ready;
    assign take        = pixel_valid && pixel_ready;

    always_comb
    begin
        prev_upper_next = prev_upper_reg;
        prev_lower_next = prev_lower_reg;
        row_start_next  = row_start_reg;
        valid_next      = valid_reg && !desc_ready;
        desc_next       = desc_reg;
        if (take)
        begin
            prev_upper_next  = upper_color;
            prev_lower_next  = lower_color;
            row_start_next   = row_end || frame_end;
            valid_next       = 1'b1;
            desc_next.open   = row_start_reg || (upper_color != prev_upper_reg)
                               || (lower_color != prev_lower_reg);
            desc_next.newline = row_end && !frame_end;
            desc_next.bcd[0] = to_bcd(upper_red);
            desc_next.bcd[1] = to_bcd(upper_green);
            desc_next.bcd[2] = to_bcd(upper_blue);
            desc_next.bcd[3] = to_bcd(lower_red);
            desc_next.bcd[4] = to_bcd(lower_green);
            desc_next.bcd[5] = to_bcd(lower_blue);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_upper_reg <= '0;
            prev_lower_reg <= '0;
            row_start_reg  <= 1'b1;
            valid_reg      <= 1'b0;
        end
        else
        begin
            prev_upper_reg <= prev_upper_next;
            prev_lower_reg <= prev_lower_next;
            row_start_reg  <= row_start_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign desc_valid = valid_reg;
    assign desc       = desc_reg;

endmodule

`default_nettype wire

// ===== rtl/phe_emit.sv =====
`default_nettype none

module phe_emit
    import phe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       desc_valid,
    output logic            desc_ready,
    input  wire desc_t      desc,
    output logic            byte_valid,
    input  wire logic       byte_ready,
    output logic [7:0]      out_byte,
    output logic            item_last
);

    // Byte and presence of one template position for the given column.
    function automatic slot_info_t slot_info(input logic [SLOT_W-1:0] s, input desc_t d);
        slot_info_t       r;
        logic             is_digit;
        logic [2:0]       ch;
        logic [SLOT_W-1:0] base;
        logic [SLOT_W-1:0] diff;
        logic [11:0]      b;
        r        = '{present: 1'b1, value: BYTE_SEMI};
        is_digit = 1'b1;
        ch       = 3'd0;
        base     = 6'd7;
        case (s) inside
            [6'd7:6'd9]:   begin ch = 3'd0; base = 6'd7;  end
            [6'd11:6'd13]: begin ch = 3'd1; base = 6'd11; end
            [6'd15:6'd17]: begin ch = 3'd2; base = 6'd15; end
            [6'd24:6'd26]: begin ch = 3'd3; base = 6'd24; end
            [6'd28:6'd30]: begin ch = 3'd4; base = 6'd28; end
            [6'd32:6'd34]: begin ch = 3'd5; base = 6'd32; end
            default:       is_digit = 1'b0;
        endcase
        diff = s - base;
        b    = d.bcd[ch];
        if (is_digit)
        begin
            case (diff[1:0])
                2'd0:
                begin
                    r.present = (b[11:8] != 4'd0);
                    r.value   = BYTE_ZERO + {4'd0, b[11:8]};
                end
                2'd1:
                begin
                    r.present = (b[11:4] != 8'd0);
                    r.value   = BYTE_ZERO + {4'd0, b[7:4]};
                end
                default:
                begin
                    r.present = 1'b1;
                    r.value   = BYTE_ZERO + {4'd0, b[3:0]};
                end
            endcase
        end
        else
        begin
            case (s)
                6'd0:  r.value = BYTE_ESC;
                6'd1:  r.value = BYTE_LBR;
                6'd2:  r.value = BYTE_THREE;
                6'd3:  r.value = BYTE_EIGHT;
                6'd5:  r.value = BYTE_TWO;
                6'd19: r.value = BYTE_FOUR;
                6'd20: r.value = BYTE_EIGHT;
                6'd22: r.value = BYTE_TWO;
                6'd35: r.value = BYTE_M;
                6'd36: r.value = BYTE_HB0;
                6'd37: r.value = BYTE_HB1;
                6'd38: r.value = BYTE_HB2;
                6'd39:
                begin
                    r.value   = BYTE_NL;
                    r.present = d.newline;
                end
                6'd4, 6'd6, 6'd10, 6'd14, 6'd18, 6'd21, 6'd23, 6'd27, 6'd31:
                    r.value = BYTE_SEMI;
                default:
                begin
                    r.value   = BYTE_SEMI;
                    r.present = 1'b0;
                end
            endcase
        end
        return r;
    endfunction

    logic              busy_reg, busy_next;
    desc_t             cur_reg, cur_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              ovalid_reg, ovalid_next;
    logic [7:0]        obyte_reg, obyte_next;
    logic              olast_reg, olast_next;
    logic              can_advance;
    logic              is_last;
    logic              take_desc;
    slot_info_t        here, ahead1, ahead2;
    logic [SLOT_W-1:0] step;

    assign can_advance = !ovalid_reg || byte_ready;
    assign is_last     = slot_reg == (cur_reg.newline ? SLOT_NL : SLOT_HALF2);
    assign desc_ready  = !busy_reg || (can_advance && is_last);
    assign take_desc   = desc_valid && desc_ready;

    assign here   = slot_info(slot_reg, cur_reg);
    assign ahead1 = slot_info(slot_reg + 6'd1, cur_reg);
    assign ahead2 = slot_info(slot_reg + 6'd2, cur_reg);

    // A run of skipped positions is at most two long: a missing hundreds
    // digit followed by a missing tens digit.
    always_comb
    begin
        if (ahead1.present)
            step = 6'd1;
        else if (ahead2.present)
            step = 6'd2;
        else
            step = 6'd3;
    end

    always_comb
    begin
        busy_next   = busy_reg;
        cur_next    = cur_reg;
        slot_next   = slot_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        if (can_advance)
        begin
            ovalid_next = busy_reg;
            if (busy_reg)
            begin
                obyte_next = here.value;
                olast_next = is_last;
                slot_next  = slot_reg + step;
                if (is_last)
                    busy_next = 1'b0;
            end
        end
        if (take_desc)
        begin
            busy_next = 1'b1;
            cur_next  = desc;
            slot_next = desc.open ? SLOT_FIRST : SLOT_HALF0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            slot_reg   <= SLOT_FIRST;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            slot_reg   <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign byte_valid = ovalid_reg;
    assign out_byte   = obyte_reg;
    assign item_last  = olast_reg;

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> slot_reg <= SLOT_NL)
        else $error("slot pointer beyond template");

    a_start_slot: assert property (@(posedge clk) disable iff (!rst_n)
        take_desc |=> (slot_reg == SLOT_FIRST || slot_reg == SLOT_HALF0))
        else $error("column started at a wrong template position");

    a_no_escape_without_run: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !cur_reg.open) |-> slot_reg >= SLOT_HALF0)
        else $error("escape byte emitted for a column that opens no run");

    a_visit_present: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> here.present)
        else $error("emitter stands on a skipped position");

endmodule

`default_nettype wire

// ===== rtl/pixel_pair_to_ansi_halfblock_encoder_top.sv =====
// Half-block true-color terminal encoder.
//
// Pixel channel: one word per column of a row pair (upper and lower RGBA,
// plus row_end and frame_end), taken on pixel_valid && pixel_ready.
// Byte channel: one terminal byte per word on byte_valid && byte_ready,
// with item_last marking the final byte that a column produces.
//
// A column that starts a row or changes any channel emits the color escape
// (up to 36 bytes), then every column emits the three-byte half block and,
// at a row end that is not a frame end, a newline. So a column produces 3 to
// 40 bytes on the byte channel, one byte per cycle while byte_ready holds, back to back.
// The first byte of a column reaches the byte port by way of registers: the
// emitter loads the column from the decode register into its own register,
// and the output register then takes the byte. The decode register takes
// the next column while the emitter still works, so the byte port is the
// only limit on throughput.
// Reset makes the next column a row start and clears the stored colors.
// When the receiver stalls, the output byte holds and the pixel channel
// backs up once the decode register is full.
`default_nettype none

module pixel_pair_to_ansi_halfblock_encoder_top
    import phe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pixel_valid,
    output logic            pixel_ready,
    input  wire logic [7:0] upper_red,
    input  wire logic [7:0] upper_green,
    input  wire logic [7:0] upper_blue,
    input  wire logic [7:0] upper_alpha,
    input  wire logic [7:0] lower_red,
    input  wire logic [7:0] lower_green,
    input  wire logic [7:0] lower_blue,
    input  wire logic [7:0] lower_alpha,
    input  wire logic       row_end,
    input  wire logic       frame_end,
    output logic            byte_valid,
    input  wire logic       byte_ready,
    output logic [7:0]      out_byte,
    output logic            item_last
);

    logic  desc_valid;
    logic  desc_ready;
    desc_t desc;

    phe_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .upper_red   (upper_red),
        .upper_green (upper_green),
        .upper_blue  (upper_blue),
        .upper_alpha (upper_alpha),
        .lower_red   (lower_red),
        .lower_green (lower_green),
        .lower_blue  (lower_blue),
        .lower_alpha (lower_alpha),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .desc_valid  (desc_valid),
        .desc_ready  (desc_ready),
        .desc        (desc)
    );

    phe_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .out_byte   (out_byte),
        .item_last  (item_last)
    );

endmodule

`default_nettype wire

// ===== tb/halfblock_stream_checker.sv =====
`default_nettype none

module halfblock_stream_checker
    import phe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pixel_valid,
    input  wire logic       pixel_ready,
    input  wire logic [7:0] upper_red,
    input  wire logic [7:0] upper_green,
    input  wire logic [7:0] upper_blue,
    input  wire logic [7:0] upper_alpha,
    input  wire logic [7:0] lower_red,
    input  wire logic [7:0] lower_green,
    input  wire logic [7:0] lower_blue,
    input  wire logic [7:0] lower_alpha,
    input  wire logic       row_end,
    input  wire logic       frame_end,
    input  wire logic       byte_valid,
    input  wire logic       byte_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       item_last,
    output int              mismatches,
    output int              bytes_owed
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } term_byte_t;

    term_byte_t  owed_bytes[$];
    term_byte_t  want;
    logic [31:0] last_upper;
    logic [31:0] last_lower;
    logic        line_start;

    function automatic void push_byte(logic [7:0] b, logic last);
        owed_bytes.push_back({b, last});
    endfunction

    // Plain decimal, no leading zeros.
    function automatic void push_decimal(logic [7:0] v);
        logic [7:0] hundreds;
        logic [7:0] tens;
        logic [7:0] ones;
        hundreds = v / 8'd100;
        tens = (v / 8'd10) % 8'd10;
        ones = v % 8'd10;
        if (v >= 8'd100)
            push_byte(BYTE_ZERO + hundreds, 1'b0);
        if (v >= 8'd10)
            push_byte(BYTE_ZERO + tens, 1'b0);
        push_byte(BYTE_ZERO + ones, 1'b0);
    endfunction

    // One SGR true-color group: "38;2;R;G;B" or "48;2;R;G;B".
    function automatic void push_sgr_color(logic [7:0] kind_digit, logic [23:0] rgb);
        push_byte(kind_digit, 1'b0);
        push_byte(BYTE_EIGHT, 1'b0);
        push_byte(BYTE_SEMI, 1'b0);
        push_byte(BYTE_TWO, 1'b0);
        push_byte(BYTE_SEMI, 1'b0);
        push_decimal(rgb[7:0]);
        push_byte(BYTE_SEMI, 1'b0);
        push_decimal(rgb[15:8]);
        push_byte(BYTE_SEMI, 1'b0);
        push_decimal(rgb[23:16]);
    endfunction

    function automatic void encode_column(logic [31:0] upper, logic [31:0] lower,
                                          logic re, logic fe);
        logic newline;
        newline = re && !fe;
        if (line_start || upper != last_upper || lower != last_lower)
        begin
            push_byte(BYTE_ESC, 1'b0);
            push_byte(BYTE_LBR, 1'b0);
            push_sgr_color(BYTE_THREE, upper[23:0]);
            push_byte(BYTE_SEMI, 1'b0);
            push_sgr_color(BYTE_FOUR, lower[23:0]);
            push_byte(BYTE_M, 1'b0);
        end
        push_byte(BYTE_HB0, 1'b0);
        push_byte(BYTE_HB1, 1'b0);
        push_byte(BYTE_HB2, !newline);
        if (newline)
            push_byte(BYTE_NL, 1'b1);
        last_upper = upper;
        last_lower = lower;
        // A frame end closes the row as well, with or without row_end.
        line_start = re || fe;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_bytes.delete();
            last_upper = '0;
            last_lower = '0;
            line_start = 1'b1;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
                encode_column({upper_alpha, upper_blue, upper_green, upper_red},
                              {lower_alpha, lower_blue, lower_green, lower_red},
                              row_end, frame_end);
            if (byte_valid && byte_ready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    $error("out_byte: nothing expected, got 0x%02h", out_byte);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (out_byte !== want.value)
                    begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", want.value, out_byte);
                        mismatches = mismatches + 1;
                    end
                    if (item_last !== want.last)
                    begin
                        $error("item_last: expected %0b, got %0b", want.last, item_last);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
        bytes_owed = owed_bytes.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;

    typedef struct packed {
        logic [7:0] ur;
        logic [7:0] ug;
        logic [7:0] ub;
        logic [7:0] ua;
        logic [7:0] lr;
        logic [7:0] lg;
        logic [7:0] lb;
        logic [7:0] la;
        logic       row_end;
        logic       frame_end;
    } column_t;

    logic       clk;
    logic       rst_n;
    logic       pixel_valid;
    logic       pixel_ready;
    logic [7:0] upper_red;
    logic [7:0] upper_green;
    logic [7:0] upper_blue;
    logic [7:0] upper_alpha;
    logic [7:0] lower_red;
    logic [7:0] lower_green;
    logic [7:0] lower_blue;
    logic [7:0] lower_alpha;
    logic       row_end;
    logic       frame_end;
    logic       byte_valid;
    logic       byte_ready;
    logic [7:0] out_byte;
    logic       item_last;

    int      mismatches;
    int      bytes_owed;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      columns_sent;
    logic    hold_request = 1'b0;
    column_t prev_col;

    pixel_pair_to_ansi_halfblock_encoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .upper_red   (upper_red),
        .upper_green (upper_green),
        .upper_blue  (upper_blue),
        .upper_alpha (upper_alpha),
        .lower_red   (lower_red),
        .lower_green (lower_green),
        .lower_blue  (lower_blue),
        .lower_alpha (lower_alpha),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .out_byte    (out_byte),
        .item_last   (item_last)
    );

    halfblock_stream_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .upper_red   (upper_red),
        .upper_green (upper_green),
        .upper_blue  (upper_blue),
        .upper_alpha (upper_alpha),
        .lower_red   (lower_red),
        .lower_green (lower_green),
        .lower_blue  (lower_blue),
        .lower_alpha (lower_alpha),
        .row_end     (row_end),
        .frame_end   (frame_end),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .out_byte    (out_byte),
        .item_last   (item_last),
        .mismatches  (mismatches),
        .bytes_owed  (bytes_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: FAIL");
        $finish;
    end

    // Byte receiver. A hold request stalls it for a long stretch so that
    // the pixel side backs up.
    initial
    begin
        byte_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                byte_ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            byte_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic column_t pixel_pair(logic [7:0] ur, logic [7:0] ug, logic [7:0] ub,
                                           logic [7:0] ua, logic [7:0] lr, logic [7:0] lg,
                                           logic [7:0] lb, logic [7:0] la,
                                           logic re, logic fe);
        return {ur, ug, ub, ua, lr, lg, lb, la, re, fe};
    endfunction

    // Biased so that one-, two- and three-digit values all show up often.
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(2))
            0: return 8'($urandom_range(9));
            1: return 8'($urandom_range(99, 10));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic column_t vary_column(column_t prev);
        column_t c;
        int      k;
        c = prev;
        case ($urandom_range(5))
            0, 1, 2: ;
            3:
            begin
                k = $urandom_range(7);
                c[65 - 8 * k -: 8] = 8'($urandom_range(255));
            end
            default:
            begin
                for (int i = 0; i < 8; i++)
                    c[65 - 8 * i -: 8] = rand_channel();
            end
        endcase
        c.row_end = 1'b0;
        c.frame_end = 1'b0;
        return c;
    endfunction

    task automatic send_column(input column_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        {upper_red, upper_green, upper_blue, upper_alpha,
         lower_red, lower_green, lower_blue, lower_alpha, row_end, frame_end} <= c;
        pixel_valid <= 1'b1;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        @(negedge clk);
        prev_col = c;
        columns_sent++;
    endtask

    // A well-formed frame has row ends on the last column of each row and a
    // frame end on the very last one. Noisy frames scatter the marks.
    task automatic send_frame(input bit noisy);
        int      rows;
        int      width;
        column_t c;
        rows = $urandom_range(3, 1);
        for (int r = 0; r < rows; r++)
        begin
            width = $urandom_range(8, 1);
            for (int x = 0; x < width; x++)
            begin
                c = vary_column(prev_col);
                if (noisy)
                begin
                    c.row_end = ($urandom_range(3) == 0);
                    c.frame_end = ($urandom_range(5) == 0);
                end
                else
                begin
                    c.row_end = (x == width - 1);
                    c.frame_end = (x == width - 1) && (r == rows - 1);
                end
                send_column(c);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        {upper_red, upper_green, upper_blue, upper_alpha,
         lower_red, lower_green, lower_blue, lower_alpha, row_end, frame_end} = '0;
        send_idle_pct = 33;
        recv_idle_pct = 60;
        columns_sent = 0;
        prev_col = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The first word after reset matches the cleared colors but still
        // opens a run because it starts a row.
        send_column(pixel_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_column(pixel_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_column(pixel_pair(255, 255, 255, 255, 255, 255, 255, 255, 0, 0));
        // Alpha alone differs, which still opens a run.
        send_column(pixel_pair(255, 255, 255, 0, 255, 255, 255, 255, 0, 0));
        send_column(pixel_pair(255, 255, 255, 0, 255, 255, 255, 7, 0, 0));
        send_column(pixel_pair(9, 10, 99, 128, 100, 0, 255, 1, 0, 0));
        send_column(pixel_pair(9, 10, 99, 128, 100, 0, 255, 1, 1, 0));
        send_column(pixel_pair(9, 10, 99, 128, 100, 0, 255, 1, 0, 0));
        // Frame end without row end: no newline, but the next word is a row start.
        send_column(pixel_pair(9, 10, 99, 128, 100, 0, 255, 1, 0, 1));
        send_column(pixel_pair(9, 10, 99, 128, 100, 0, 255, 1, 0, 0));
        send_column(pixel_pair(1, 2, 3, 4, 5, 6, 7, 8, 1, 1));
        send_column(pixel_pair(1, 2, 3, 4, 5, 6, 7, 8, 1, 0));
        send_column(pixel_pair(170, 85, 170, 85, 85, 170, 85, 170, 0, 0));
        send_column(pixel_pair(85, 170, 85, 170, 170, 85, 170, 85, 0, 1));
        send_column(pixel_pair(200, 199, 100, 0, 19, 20, 90, 0, 1, 0));
        send_column(pixel_pair(200, 199, 100, 0, 19, 20, 90, 0, 0, 0));

        while (columns_sent < 70)
            send_frame($urandom_range(4) == 0);

        send_idle_pct = 60;
        recv_idle_pct = 33;
        while (columns_sent < 120)
            send_frame($urandom_range(4) == 0);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        while (columns_sent < 170)
            send_frame($urandom_range(4) == 0);
        pixel_valid <= 1'b0;

        wait (bytes_owed == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && bytes_owed == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
